FILE: rtl/core/fds_pkg.sv
`default_nettype none

package fds_pkg;

  // Field widths
  localparam int unsigned FLOW_W   = 4;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned PERIOD_W = 40;
  localparam int unsigned PHASE_W  = 2;

  // Flow table sizing
  localparam int unsigned NUM_FLOWS_DEFAULT = 16;
  localparam int unsigned FLOW_SPACE        = 2 ** FLOW_W;
  localparam int unsigned FLOW_CMP_W        = 17;

  // Sample period after reset
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd1000000000;

  // Event codes on the kind field
  typedef enum logic [1:0] {
    KIND_RECV = 2'd0,
    KIND_SEND = 2'd1,
    KIND_ACK  = 2'd2
  } kind_e;

  // Sampler states
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  // One classified event moving from the front to the back
  typedef struct packed {
    kind_e               kind;
    logic [FLOW_W-1:0]   flow;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   arrival;
    logic [SEQ_W-1:0]    seq;
  } evt_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcp_flow_delay_sampler_top.sv
// Channel   Handshake                Beat contents
// event     in_valid_i / in_stall_o  kind, flow, now_ns, arrival_ns, seq, send_succeeded
// report    out_valid_o / out_stall_i report_flow, send/recv delay, send/recv phase
// period    sample_period_ns_we_i     sample_period_ns_i, registered on the strobe
//
// One event per cycle while out_stall_i does not hold the report register; an event
// passes a queue slot, then its report the output register. The per-flow read-modify-write sets
// the rate. Reset clears the whole flow table at once; no clearing pass follows.
// A two-entry queue parts the input from the execute stage, so in_stall_o
// rises only when the queue is full behind a stalled report register.
`default_nettype none

module tcp_flow_delay_sampler_top import fds_pkg::*; #(
  parameter int unsigned NUM_FLOWS = NUM_FLOWS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_period_ns_we_i,
  input  logic [PERIOD_W-1:0] sample_period_ns_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [FLOW_W-1:0]   flow_i,
  input  logic [TIME_W-1:0]   now_ns_i,
  input  logic [TIME_W-1:0]   arrival_ns_i,
  input  logic [SEQ_W-1:0]    seq_i,
  input  logic                send_succeeded_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FLOW_W-1:0]   report_flow_o,
  output logic [TIME_W-1:0]   send_delay_ns_o,
  output logic [TIME_W-1:0]   recv_delay_ns_o,
  output logic [PHASE_W-1:0]  send_phase_o,
  output logic [PHASE_W-1:0]  recv_phase_o
);

  logic push, pop, q_full, q_nonempty;
  evt_t evt_in, evt_out;

  // Classify incoming beats
  fds_front #(
    .NUM_FLOWS(NUM_FLOWS)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .q_full_i         (q_full),
    .kind_i           (kind_i),
    .flow_i           (flow_i),
    .now_ns_i         (now_ns_i),
    .arrival_ns_i     (arrival_ns_i),
    .seq_i            (seq_i),
    .send_succeeded_i (send_succeeded_i),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .evt_o            (evt_in)
  );

  // Buffer events between front and back
  fds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .evt_i      (evt_in),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .evt_o      (evt_out)
  );

  // Execute against the flow table
  fds_back #(
    .NUM_FLOWS(NUM_FLOWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .period_we_i     (sample_period_ns_we_i),
    .period_i        (sample_period_ns_i),
    .q_nonempty_i    (q_nonempty),
    .evt_i           (evt_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .report_flow_o   (report_flow_o),
    .send_delay_ns_o (send_delay_ns_o),
    .recv_delay_ns_o (recv_delay_ns_o),
    .send_phase_o    (send_phase_o),
    .recv_phase_o    (recv_phase_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/fds_front.sv
`default_nettype none

module fds_front import fds_pkg::*; #(
  parameter int unsigned NUM_FLOWS = NUM_FLOWS_DEFAULT
) (
  input  logic                in_valid_i,
  input  logic                q_full_i,
  input  logic [1:0]          kind_i,
  input  logic [FLOW_W-1:0]   flow_i,
  input  logic [TIME_W-1:0]   now_ns_i,
  input  logic [TIME_W-1:0]   arrival_ns_i,
  input  logic [SEQ_W-1:0]    seq_i,
  input  logic                send_succeeded_i,
  output logic                in_stall_o,
  output logic                push_o,
  output evt_t                evt_o
);

  localparam logic [FLOW_CMP_W-1:0] FlowLimit = FLOW_CMP_W'(NUM_FLOWS);

  logic  keep;
  logic  in_range;
  kind_e kind;

  // Drop events that can never touch the table
  assign in_range = FLOW_CMP_W'(flow_i) < FlowLimit;

  always_comb begin
    keep = 1'b0;
    kind = KIND_RECV;
    unique case (kind_i)
      KIND_RECV: begin
        kind = KIND_RECV;
        keep = in_range;
      end
      KIND_SEND: begin
        kind = KIND_SEND;
        keep = in_range && send_succeeded_i;
      end
      KIND_ACK: begin
        kind = KIND_ACK;
        keep = in_range;
      end
      default: begin
        kind = KIND_RECV;
        keep = 1'b0;
      end
    endcase
  end

  // Stall only while the queue is full; dropped beats are taken anyway
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  assign evt_o.kind    = kind;
  assign evt_o.flow    = flow_i;
  assign evt_o.now     = now_ns_i;
  assign evt_o.arrival = arrival_ns_i;
  assign evt_o.seq     = seq_i;

endmodule

`default_nettype wire

FILE: rtl/core/fds_queue.sv
`default_nettype none

module fds_queue import fds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t evt_i,
  input  logic pop_i,
  output logic full_o,
  output logic nonempty_o,
  output evt_t evt_o
);

  evt_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign nonempty_o = count_q != 2'd0;
  assign evt_o      = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= evt_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fds_back.sv
`default_nettype none

module fds_back import fds_pkg::*; #(
  parameter int unsigned NUM_FLOWS = NUM_FLOWS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  period_we_i,
  input  logic [PERIOD_W-1:0]   period_i,
  input  logic                  q_nonempty_i,
  input  evt_t                  evt_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FLOW_W-1:0]     report_flow_o,
  output logic [TIME_W-1:0]     send_delay_ns_o,
  output logic [TIME_W-1:0]     recv_delay_ns_o,
  output logic [PHASE_W-1:0]    send_phase_o,
  output logic [PHASE_W-1:0]    recv_phase_o
);

  // Only flows reachable through the flow field need an entry
  localparam int unsigned DEPTH = (NUM_FLOWS < FLOW_SPACE) ? NUM_FLOWS : FLOW_SPACE;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PERIOD_W-1:0] period_q;

  phase_e            send_phase_q [DEPTH];
  phase_e            recv_phase_q [DEPTH];
  logic [SEQ_W-1:0]  armed_seq_q  [DEPTH];
  logic [TIME_W-1:0] send_start_q [DEPTH];
  logic [TIME_W-1:0] send_delay_q [DEPTH];
  logic [TIME_W-1:0] recv_delay_q [DEPTH];
  logic [TIME_W-1:0] last_rpt_q   [DEPTH];

  logic [IDX_W-1:0]  idx;
  phase_e            sp_rd, rp_rd, sp_cur;
  logic [SEQ_W-1:0]  aseq_rd;
  logic [TIME_W-1:0] start_rd, sd_rd, rd_rd, last_rd;
  phase_e            sp_d, rp_d;
  logic [SEQ_W-1:0]  aseq_d;
  logic [TIME_W-1:0] start_d, sd_d, rd_d, last_d;
  logic [TIME_W-1:0] since_last, recv_gap, send_gap;
  logic              elapsed;
  logic              report;

  logic                 out_valid_q, out_valid_d;
  logic [FLOW_W-1:0]    rpt_flow_q;
  logic [TIME_W-1:0]    rpt_sd_q, rpt_rd_q;
  logic [PHASE_W-1:0]   rpt_sp_q, rpt_rp_q;

  // Take the next event whenever the output register is free or draining
  assign pop_o = q_nonempty_i && (!out_valid_q || !out_stall_i);

  // Read the flow entry
  assign idx      = IDX_W'(evt_i.flow);
  assign sp_rd    = send_phase_q[idx];
  assign rp_rd    = recv_phase_q[idx];
  assign aseq_rd  = armed_seq_q[idx];
  assign start_rd = send_start_q[idx];
  assign sd_rd    = send_delay_q[idx];
  assign rd_rd    = recv_delay_q[idx];
  assign last_rd  = last_rpt_q[idx];

  // Period check and delay differences
  assign since_last = evt_i.now - last_rd;
  assign recv_gap   = evt_i.now - evt_i.arrival;
  assign send_gap   = evt_i.now - start_rd;
  assign elapsed    = (evt_i.now > last_rd) && (since_last > TIME_W'(period_q));

  // Update the sampler entry for one event
  always_comb begin
    sp_d    = sp_rd;
    rp_d    = rp_rd;
    aseq_d  = aseq_rd;
    start_d = start_rd;
    sd_d    = sd_rd;
    rd_d    = rd_rd;
    last_d  = last_rd;
    sp_cur  = sp_rd;
    report  = 1'b0;
    unique case (evt_i.kind)
      KIND_RECV: begin
        if (!(rp_rd == PH_DONE && !elapsed)) begin
          if (rp_rd == PH_DONE) begin
            report = 1'b1;
            last_d = evt_i.now;
            sp_d   = PH_IDLE;
            rp_d   = PH_IDLE;
          end
          if (evt_i.arrival != '0 && evt_i.arrival < evt_i.now) begin
            rd_d = recv_gap;
            rp_d = PH_DONE;
          end
        end
      end
      KIND_SEND: begin
        if (!(sp_rd == PH_DONE && !elapsed)) begin
          if (sp_rd == PH_DONE) begin
            report = 1'b1;
            last_d = evt_i.now;
            sp_cur = PH_IDLE;
            sp_d   = PH_IDLE;
            rp_d   = PH_IDLE;
          end
          // Arm when not armed; re-arm only on a lower sequence
          if (!(sp_cur == PH_ARMED && aseq_rd <= evt_i.seq)) begin
            start_d = evt_i.now;
            aseq_d  = evt_i.seq;
            sp_d    = PH_ARMED;
          end
        end
      end
      KIND_ACK: begin
        if (sp_rd == PH_ARMED && aseq_rd <= evt_i.seq) begin
          if (evt_i.now > start_rd) begin
            sd_d = send_gap;
            sp_d = PH_DONE;
          end else begin
            sp_d = PH_IDLE;
          end
        end
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  // Write back the flow entry and the period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        send_phase_q[i] <= PH_IDLE;
        recv_phase_q[i] <= PH_IDLE;
        armed_seq_q[i]  <= '0;
        send_start_q[i] <= '0;
        send_delay_q[i] <= '0;
        recv_delay_q[i] <= '0;
        last_rpt_q[i]   <= '0;
      end
    end else begin
      if (period_we_i) begin
        period_q <= period_i;
      end
      if (pop_o) begin
        send_phase_q[idx] <= sp_d;
        recv_phase_q[idx] <= rp_d;
        armed_seq_q[idx]  <= aseq_d;
        send_start_q[idx] <= start_d;
        send_delay_q[idx] <= sd_d;
        recv_delay_q[idx] <= rd_d;
        last_rpt_q[idx]   <= last_d;
      end
    end
  end

  // Output register: load a report, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = report;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && report) begin
      rpt_flow_q <= evt_i.flow;
      rpt_sd_q   <= sd_rd;
      rpt_rd_q   <= rd_rd;
      rpt_sp_q   <= sp_rd;
      rpt_rp_q   <= rp_rd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign report_flow_o   = rpt_flow_q;
  assign send_delay_ns_o = rpt_sd_q;
  assign recv_delay_ns_o = rpt_rd_q;
  assign send_phase_o    = rpt_sp_q;
  assign recv_phase_o    = rpt_rp_q;

endmodule

`default_nettype wire

FILE: rtl/core/fds_checker.sv
`default_nettype none

module fds_checker import fds_pkg::*; #(
  parameter int unsigned NUM_FLOWS = NUM_FLOWS_DEFAULT
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input logic [FLOW_W-1:0]   report_flow_i,
  input logic [TIME_W-1:0]   send_delay_ns_i,
  input logic [TIME_W-1:0]   recv_delay_ns_i,
  input logic [PHASE_W-1:0]  send_phase_i,
  input logic [PHASE_W-1:0]  recv_phase_i
);

  localparam logic [FLOW_CMP_W-1:0] FlowLimit = FLOW_CMP_W'(NUM_FLOWS);

  // A stalled report beat holds
  a_report_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(report_flow_i)
      && $stable(send_delay_ns_i) && $stable(recv_delay_ns_i)
      && $stable(send_phase_i) && $stable(recv_phase_i))
    else $error("report beat changed while stalled");

  // A report is only raised by a finished sampler
  a_report_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (send_phase_i == PH_DONE || recv_phase_i == PH_DONE))
    else $error("report without a finished sampler");

  // The receive sampler is never armed, and reports name a tracked flow
  a_report_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> recv_phase_i != PH_ARMED
      && (FLOW_CMP_W'(report_flow_i) < FlowLimit))
    else $error("report with bad flow or receive phase");

endmodule

bind tcp_flow_delay_sampler_top fds_checker #(
  .NUM_FLOWS(NUM_FLOWS)
) u_fds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .report_flow_i   (report_flow_o),
  .send_delay_ns_i (send_delay_ns_o),
  .recv_delay_ns_i (recv_delay_ns_o),
  .send_phase_i    (send_phase_o),
  .recv_phase_i    (recv_phase_o)
);

`default_nettype wire
